[rtl/core/pott_pkg.sv]
// shared types and codes for the periodic/one-shot timer table
// no dependencies; imported by pott_ctrl, pott_dp and the top level
package pott_pkg;

  // default sizes for the top-level parameters
  localparam int SLOTS_DEF     = 16;
  localparam int TIME_BITS_DEF = 32;

  // operation codes carried by an input item (6 and 7 are unused)
  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_CREATE  = 3'd1,
    OP_DELETE  = 3'd2,
    OP_ENABLE  = 3'd3,
    OP_DISABLE = 3'd4,
    OP_RESTART = 3'd5
  } op_t;

  // result event kinds
  typedef enum logic [1:0] {
    EV_ACK       = 2'd0,
    EV_FIRED     = 2'd1,
    EV_SCAN_DONE = 2'd2
  } event_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_FREE = 2'd2
  } status_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DONE
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;      // capture the input item
    logic tick_inc;  // advance the tick count
    logic scan_go;   // arm the slot scan
    logic exec;      // run a non-tick operation
    logic scan;      // scan step
    logic finish;    // emit scan-finished result
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic scan_end;  // last slot is being evaluated
  } dp_stat_t;

endpackage

[rtl/core/pott_ctrl.sv]
// controller state machine for the timer table
// depends on pott_pkg; drives commands into pott_dp
module pott_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [2:0]        in_operation,
  input  pott_pkg::dp_stat_t stat,
  output logic              busy,
  output pott_pkg::dp_cmd_t cmd
);
  import pott_pkg::*;

  state_t state_r, state_nxt;
  logic   accept;
  logic   is_tick;

  assign accept  = start && (state_r == S_IDLE);
  assign is_tick = (in_operation == OP_TICK);

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = is_tick ? S_SCAN : S_EXEC;
        end
      end
      S_EXEC: state_nxt = S_IDLE;
      S_SCAN: begin
        if (stat.scan_end) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd          = '0;
    busy         = (state_r != S_IDLE);
    cmd.load     = accept;
    cmd.tick_inc = accept && is_tick;
    cmd.scan_go  = accept && is_tick;
    cmd.exec     = (state_r == S_EXEC);
    cmd.scan     = (state_r == S_SCAN);
    cmd.finish   = (state_r == S_DONE);
  end

endmodule

[rtl/core/pott_dp.sv]
// datapath for the timer table: slot flags, delay and fire-time memories,
// tick count, scan pointers and the result register; depends on pott_pkg
module pott_dp #(
  parameter int SLOTS     = pott_pkg::SLOTS_DEF,
  parameter int TIME_BITS = pott_pkg::TIME_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pott_pkg::dp_cmd_t  cmd,
  output pott_pkg::dp_stat_t stat,
  input  logic [2:0]         in_operation,
  input  logic [3:0]         in_timer_id,
  input  logic [31:0]        in_delay_ticks,
  input  logic               in_periodic,
  output logic               out_valid,
  output logic [1:0]         out_event_res,
  output logic [1:0]         out_status,
  output logic [3:0]         out_slot_index,
  output logic               out_last
);
  import pott_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  // captured item
  logic [2:0]           op_r;
  logic [3:0]           id_r;
  logic [TIME_BITS-1:0] dly_r;
  logic                 per_in_r;

  // slot flags
  logic [SLOTS-1:0] used_r, used_nxt;
  logic [SLOTS-1:0] en_r, en_nxt;
  logic [SLOTS-1:0] per_r, per_nxt;

  logic [TIME_BITS-1:0] tick_now_r;

  // delay and fire-time memories
  logic [TIME_BITS-1:0] dly_mem  [SLOTS];
  logic [TIME_BITS-1:0] last_mem [SLOTS];
  logic [TIME_BITS-1:0] rd_dly_r, rd_last_r;
  logic                 dly_we, last_we;
  logic [IDX_W-1:0]     dly_wa, last_wa;

  // scan pointers
  logic [IDX_W-1:0] rd_ptr_r, ev_ptr_r;
  logic             rd_on_r, ev_on_r;

  // result register
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] out_ev_r, out_ev_nxt;
  logic [1:0] out_st_r, out_st_nxt;
  logic [3:0] out_idx_r, out_idx_nxt;
  logic       out_last_r, out_last_nxt;

  // lookups
  logic [IDX_W-1:0]     free_idx;
  logic                 full;
  logic [IDX_W-1:0]     id_idx;
  logic                 id_ok;
  logic [TIME_BITS-1:0] elapsed;
  logic                 fire;

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end
  assign full = &used_r;

  // addressed slot must exist and be in use
  assign id_idx = IDX_W'(id_r);
  assign id_ok  = ({3'b000, id_r} < 7'(SLOTS)) && used_r[id_idx];

  // wrapping elapsed time against the delay of the slot under evaluation
  assign elapsed = tick_now_r - rd_last_r;
  assign fire    = used_r[ev_ptr_r] && en_r[ev_ptr_r] && (elapsed >= rd_dly_r);

  assign stat.scan_end = ev_on_r && (ev_ptr_r == LAST_IDX);

  // operation decode, scan evaluation and result
  always_comb begin
    used_nxt      = used_r;
    en_nxt        = en_r;
    per_nxt       = per_r;
    dly_we        = 1'b0;
    dly_wa        = free_idx;
    last_we       = 1'b0;
    last_wa       = free_idx;
    out_valid_nxt = 1'b0;
    out_ev_nxt    = EV_ACK;
    out_st_nxt    = ST_OK;
    out_idx_nxt   = id_r;
    out_last_nxt  = 1'b1;

    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
      unique case (op_r)
        OP_CREATE: begin
          if (full) begin
            out_st_nxt  = ST_FULL;
            out_idx_nxt = '0;
          end else begin
            used_nxt[free_idx] = 1'b1;
            en_nxt[free_idx]   = 1'b1;
            per_nxt[free_idx]  = per_in_r;
            dly_we             = 1'b1;
            last_we            = 1'b1;
            out_idx_nxt        = 4'(free_idx);
          end
        end
        OP_DELETE, OP_ENABLE, OP_DISABLE, OP_RESTART: begin
          if (!id_ok) begin
            out_st_nxt = ST_FREE;
          end else begin
            unique case (op_r)
              OP_DELETE: begin
                used_nxt[id_idx] = 1'b0;
                en_nxt[id_idx]   = 1'b0;
              end
              OP_ENABLE:  en_nxt[id_idx] = 1'b1;
              OP_DISABLE: en_nxt[id_idx] = 1'b0;
              default: begin
                last_we = 1'b1;
                last_wa = id_idx;
              end
            endcase
          end
        end
        // unused codes just acknowledge
        default: out_st_nxt = ST_OK;
      endcase
    end else if (cmd.scan && ev_on_r && fire) begin
      out_valid_nxt = 1'b1;
      out_ev_nxt    = EV_FIRED;
      out_idx_nxt   = 4'(ev_ptr_r);
      out_last_nxt  = 1'b0;
      last_we       = 1'b1;
      last_wa       = ev_ptr_r;
      if (!per_r[ev_ptr_r]) begin
        used_nxt[ev_ptr_r] = 1'b0;
        en_nxt[ev_ptr_r]   = 1'b0;
      end
    end else if (cmd.finish) begin
      out_valid_nxt = 1'b1;
      out_ev_nxt    = EV_SCAN_DONE;
      out_idx_nxt   = '0;
    end
  end

  // memories, one write and one registered read each
  always_ff @(posedge clk) begin
    if (dly_we) begin
      dly_mem[dly_wa] <= dly_r;
    end
    rd_dly_r <= dly_mem[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (last_we) begin
      last_mem[last_wa] <= tick_now_r;
    end
    rd_last_r <= last_mem[rd_ptr_r];
  end

  // item capture and payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_operation;
      id_r     <= in_timer_id;
      dly_r    <= TIME_BITS'(in_delay_ticks);
      per_in_r <= in_periodic;
    end
    per_r     <= per_nxt;
    out_ev_r  <= out_ev_nxt;
    out_st_r  <= out_st_nxt;
    out_idx_r <= out_idx_nxt;
    out_last_r <= out_last_nxt;
  end

  // control state: flags, tick count, scan pointers, strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      en_r        <= '0;
      tick_now_r  <= '0;
      rd_ptr_r    <= '0;
      ev_ptr_r    <= '0;
      rd_on_r     <= 1'b0;
      ev_on_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      used_r      <= used_nxt;
      en_r        <= en_nxt;
      out_valid_r <= out_valid_nxt;
      if (cmd.tick_inc) begin
        tick_now_r <= tick_now_r + TIME_BITS'(1);
      end
      if (cmd.scan_go) begin
        rd_ptr_r <= '0;
        rd_on_r  <= 1'b1;
        ev_on_r  <= 1'b0;
      end else if (cmd.scan) begin
        ev_on_r  <= rd_on_r;
        ev_ptr_r <= rd_ptr_r;
        if (rd_on_r) begin
          rd_ptr_r <= rd_ptr_r + IDX_W'(1);
          if (rd_ptr_r == LAST_IDX) begin
            rd_on_r <= 1'b0;
          end
        end
      end else begin
        ev_on_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_res  = out_ev_r;
  assign out_status     = out_st_r;
  assign out_slot_index = out_idx_r;
  assign out_last       = out_last_r;

endmodule

[rtl/core/periodic_oneshot_timer_table.sv]
// top level of the periodic/one-shot timer table
// depends on pott_pkg, pott_ctrl and pott_dp
//
//  channel  handshake          payload
//  input    start / busy       in_operation, in_timer_id, in_delay_ticks, in_periodic
//  result   out_valid (strobe) out_event_res, out_status, out_slot_index, out_last
//
// a tick item keeps busy high while it scans the table, one slot a cycle through the
// registered read ports of the delay and fire-time memories, and while it emits the
// scan-finished result; no new item is taken until busy is low again
// every other operation keeps busy high while it executes and likewise holds off new items;
// its result is on the ports in the cycle after its busy cycle
// reset clears the in-use and enabled flags and the tick count
// results are strobed for one cycle each and the receiver cannot stall them
module periodic_oneshot_timer_table #(
  parameter int SLOTS     = pott_pkg::SLOTS_DEF,
  parameter int TIME_BITS = pott_pkg::TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_operation,
  input  logic [3:0]  in_timer_id,
  input  logic [31:0] in_delay_ticks,
  input  logic        in_periodic,
  output logic        out_valid,
  output logic [1:0]  out_event_res,
  output logic [1:0]  out_status,
  output logic [3:0]  out_slot_index,
  output logic        out_last
);
  import pott_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  pott_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .stat         (stat),
    .busy         (busy),
    .cmd          (cmd)
  );

  // slot table and result register
  pott_dp #(
    .SLOTS     (SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_operation   (in_operation),
    .in_timer_id    (in_timer_id),
    .in_delay_ticks (in_delay_ticks),
    .in_periodic    (in_periodic),
    .out_valid      (out_valid),
    .out_event_res  (out_event_res),
    .out_status     (out_status),
    .out_slot_index (out_slot_index),
    .out_last       (out_last)
  );

`ifndef SYNTH
  // a result only follows a busy cycle
  a_res_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without preceding work");

  // the final result of an item arrives once the block is free again
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !busy)
    else $error("final result while still busy");

  // an accepted item keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not start work");

  // fired results are never the final one of a tick and always carry ok status
  a_fired_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_res == EV_FIRED) |-> !out_last && (out_status == ST_OK))
    else $error("fired result flagged last or with bad status");
`endif

endmodule

[dv/periodic_oneshot_timer_table_tb.sv]
// self-checking testbench for the periodic/one-shot timer table
// needs pott_pkg and periodic_oneshot_timer_table; drives directed and random timer
// commands, predicts every result item and checks each one as it is strobed out
module periodic_oneshot_timer_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pott_pkg::*;

  localparam int N_SLOTS      = SLOTS_DEF;
  localparam int RANDOM_ITEMS = 330;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PRINT_CAP    = 40;

  // operation codes with no function
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [2:0]  op;
    logic [3:0]  id;
    logic [31:0] delay;
    logic        per;
    logic [7:0]  gap;
  } timer_cmd_t;

  typedef struct packed {
    event_t     ev;
    status_t    st;
    logic [3:0] slot;
    logic       last;
  } timer_result_t;

  logic        clk;
  logic        rst_n          = 1'b0;
  logic        start          = 1'b0;
  logic        busy;
  logic [2:0]  in_operation   = '0;
  logic [3:0]  in_timer_id    = '0;
  logic [31:0] in_delay_ticks = '0;
  logic        in_periodic    = 1'b0;
  logic        out_valid;
  logic [1:0]  out_event_res;
  logic [1:0]  out_status;
  logic [3:0]  out_slot_index;
  logic        out_last;

  periodic_oneshot_timer_table dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_operation  (in_operation),
    .in_timer_id   (in_timer_id),
    .in_delay_ticks(in_delay_ticks),
    .in_periodic   (in_periodic),
    .out_valid     (out_valid),
    .out_event_res (out_event_res),
    .out_status    (out_status),
    .out_slot_index(out_slot_index),
    .out_last      (out_last)
  );

  // commands waiting to be driven and results waiting to be seen
  timer_cmd_t    cmds_pending[$];
  timer_result_t timer_results_due[$];
  timer_cmd_t    cur_cmd;
  int            hold_off       = 0;
  int            cmds_accepted  = 0;
  int            cmds_total     = 0;
  int            mismatch_count = 0;
  int            quiet_cycles   = 0;
  logic          no_idle        = 1'b0;

  // predicted timer table
  logic        tm_used     [N_SLOTS];
  logic        tm_enabled  [N_SLOTS];
  logic        tm_periodic [N_SLOTS];
  logic [31:0] tm_delay    [N_SLOTS];
  logic [31:0] tm_last_fire[N_SLOTS];
  logic [31:0] tm_now;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
  endtask

  task automatic push_result(input event_t ev, input status_t st, input logic [3:0] slot,
                             input logic last);
    timer_result_t r;
    r.ev   = ev;
    r.st   = st;
    r.slot = slot;
    r.last = last;
    timer_results_due.push_back(r);
  endtask

  // advance the predicted table by one accepted item and queue its results
  task automatic predict_timer_results(input timer_cmd_t c);
    logic [31:0] elapsed;
    int          s;
    int          free_slot;
    if (c.op == OP_TICK) begin
      tm_now = tm_now + 32'd1;
      for (s = 0; s < N_SLOTS; s++) begin
        elapsed = tm_now - tm_last_fire[s];
        if (tm_used[s] && tm_enabled[s] && elapsed >= tm_delay[s]) begin
          push_result(EV_FIRED, ST_OK, 4'(s), 1'b0);
          tm_last_fire[s] = tm_now;
          if (!tm_periodic[s]) begin
            tm_used[s]    = 1'b0;
            tm_enabled[s] = 1'b0;
          end
        end
      end
      push_result(EV_SCAN_DONE, ST_OK, 4'd0, 1'b1);
    end else if (c.op == OP_CREATE) begin
      free_slot = -1;
      for (s = N_SLOTS - 1; s >= 0; s--)
        if (!tm_used[s]) free_slot = s;
      if (free_slot < 0) begin
        push_result(EV_ACK, ST_FULL, 4'd0, 1'b1);
      end else begin
        tm_used[free_slot]      = 1'b1;
        tm_enabled[free_slot]   = 1'b1;
        tm_periodic[free_slot]  = c.per;
        tm_delay[free_slot]     = c.delay;
        tm_last_fire[free_slot] = tm_now;
        push_result(EV_ACK, ST_OK, 4'(free_slot), 1'b1);
      end
    end else if (c.op > OP_RESTART) begin
      push_result(EV_ACK, ST_OK, c.id, 1'b1);
    end else if (!tm_used[c.id]) begin
      push_result(EV_ACK, ST_FREE, c.id, 1'b1);
    end else begin
      case (c.op)
        OP_DELETE: begin
          tm_used[c.id]    = 1'b0;
          tm_enabled[c.id] = 1'b0;
        end
        OP_ENABLE:  tm_enabled[c.id] = 1'b1;
        OP_DISABLE: tm_enabled[c.id] = 1'b0;
        default:    tm_last_fire[c.id] = tm_now;
      endcase
      push_result(EV_ACK, ST_OK, c.id, 1'b1);
    end
  endtask

  // gap before an item: mostly none or short, a few long
  function automatic logic [7:0] rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 8'd0;
    if (r < 85) return 8'($urandom_range(1, 3));
    if (r < 97) return 8'($urandom_range(4, 15));
    return 8'($urandom_range(20, 45));
  endfunction

  // create delays: mostly short so timers fire, sometimes anything
  function automatic logic [31:0] rand_delay();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 32'($urandom_range(0, 6));
    if (r < 90) return 32'($urandom_range(0, 40));
    return $urandom;
  endfunction

  task automatic queue_cmd(input logic [2:0] op, input logic [3:0] id,
                           input logic [31:0] delay, input logic per);
    timer_cmd_t c;
    c.op    = op;
    c.id    = id;
    c.delay = delay;
    c.per   = per;
    c.gap   = rand_gap();
    cmds_pending.push_back(c);
    cmds_total++;
  endtask

  // driver: holds an item until accepted, then waits out the next gap
  always @(posedge clk) begin : item_driver
    logic       start_nx;
    timer_cmd_t nxt;
    int         s;
    start_nx = start;
    if (!rst_n) begin
      start_nx = 1'b0;
      hold_off = 0;
      tm_now   = '0;
      for (s = 0; s < N_SLOTS; s++) begin
        tm_used[s]    = 1'b0;
        tm_enabled[s] = 1'b0;
      end
    end else begin
      if (start && !busy) begin
        predict_timer_results(cur_cmd);
        cmds_accepted++;
        start_nx = 1'b0;
        hold_off = (cmds_pending.size() > 0) ? int'(cmds_pending[0].gap) : 0;
      end
      if (!start_nx) begin
        if (hold_off > 0) begin
          hold_off--;
        end else if (cmds_pending.size() > 0) begin
          nxt            = cmds_pending.pop_front();
          cur_cmd        = nxt;
          in_operation   <= nxt.op;
          in_timer_id    <= nxt.id;
          in_delay_ticks <= nxt.delay;
          in_periodic    <= nxt.per;
          start_nx       = 1'b1;
        end
      end
    end
    start <= start_nx;
  end

  // monitor: every strobed result is matched against the oldest prediction
  always @(posedge clk) begin : result_check
    timer_result_t want;
    if (rst_n && out_valid) begin
      if (timer_results_due.size() == 0) begin
        report_mismatch("result with none due, slot", 32'(out_slot_index), 32'd0);
      end else begin
        want = timer_results_due.pop_front();
        if (out_event_res !== want.ev)
          report_mismatch("event", 32'(out_event_res), 32'(want.ev));
        if (out_status !== want.st)
          report_mismatch("status", 32'(out_status), 32'(want.st));
        if (out_slot_index !== want.slot)
          report_mismatch("slot", 32'(out_slot_index), 32'(want.slot));
        if (out_last !== want.last)
          report_mismatch("last", 32'(out_last), 32'(want.last));
      end
    end
  end

  // watchdog on cycles with no accepted item and no result
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("periodic_oneshot_timer_table_tb failed");
      $finish;
    end
  end

  // stimulus, end of test and verdict
  initial begin
    int i;
    int n;
    int r;

    // free-slot accesses, spare codes and a scan of the empty table
    queue_cmd(OP_TICK, 4'd0, 32'd0, 1'b0);
    queue_cmd(OP_DELETE, 4'd0, 32'd0, 1'b0);
    queue_cmd(OP_ENABLE, 4'd15, 32'hFFFF_FFFF, 1'b1);
    queue_cmd(OP_SPARE_6, 4'd9, 32'hFFFF_FFFF, 1'b1);
    queue_cmd(OP_SPARE_7, 4'd15, 32'd0, 1'b0);
    // fill the table: zero delay, never-firing, short one-shots and periodics
    for (i = 0; i < N_SLOTS; i++) begin
      if (i == 0)      queue_cmd(OP_CREATE, 4'd0, 32'd0, 1'b1);
      else if (i == 1) queue_cmd(OP_CREATE, 4'd0, 32'hFFFF_FFFF, 1'b0);
      else if (i == 2) queue_cmd(OP_CREATE, 4'd0, 32'd1, 1'b0);
      else             queue_cmd(OP_CREATE, 4'(i), 32'(i % 5), i[0]);
    end
    // table full, then fires and the other operations on live slots
    queue_cmd(OP_CREATE, 4'd0, 32'd5, 1'b1);
    queue_cmd(OP_TICK, 4'd0, 32'd0, 1'b0);
    queue_cmd(OP_DISABLE, 4'd0, 32'd0, 1'b0);
    queue_cmd(OP_RESTART, 4'd3, 32'd0, 1'b0);
    queue_cmd(OP_DELETE, 4'd1, 32'd0, 1'b0);
    queue_cmd(OP_TICK, 4'd0, 32'd0, 1'b0);

    // random part: weighted single commands plus delete sweeps and create bursts
    n = 0;
    while (n < RANDOM_ITEMS) begin
      if (n % 32 == 0) no_idle = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 3) begin
        for (i = 0; i < N_SLOTS; i++) queue_cmd(OP_DELETE, 4'(i), $urandom, 1'($urandom));
        n += N_SLOTS;
      end else if (r < 6) begin
        for (i = 0; i <= N_SLOTS; i++)
          queue_cmd(OP_CREATE, 4'($urandom), rand_delay(), 1'($urandom));
        n += N_SLOTS + 1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 42)      queue_cmd(OP_TICK, 4'($urandom), $urandom, 1'($urandom));
        else if (r < 66) queue_cmd(OP_CREATE, 4'($urandom), rand_delay(), 1'($urandom));
        else if (r < 75) queue_cmd(OP_DELETE, 4'($urandom), $urandom, 1'($urandom));
        else if (r < 82) queue_cmd(OP_ENABLE, 4'($urandom), $urandom, 1'($urandom));
        else if (r < 89) queue_cmd(OP_DISABLE, 4'($urandom), $urandom, 1'($urandom));
        else if (r < 96) queue_cmd(OP_RESTART, 4'($urandom), $urandom, 1'($urandom));
        else if (r < 98) queue_cmd(OP_SPARE_6, 4'($urandom), $urandom, 1'($urandom));
        else             queue_cmd(OP_SPARE_7, 4'($urandom), $urandom, 1'($urandom));
        n++;
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // wait for every item to be taken and every result to come back
    do @(negedge clk);
    while (cmds_accepted != cmds_total || timer_results_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0 && timer_results_due.size() == 0) begin
      $display("periodic_oneshot_timer_table_tb passed");
    end else begin
      $display("periodic_oneshot_timer_table_tb failed");
    end
    $finish;
  end

endmodule
